// ----- design/lpht_pkg.sv -----
// Shared types and constants for the linear-probing hash table.
// Used by the front end, the request queue, the probe engine and the top level.
`default_nettype none

package lpht_pkg;

	// Field widths fixed by the interface
	localparam int KEY_W    = 31;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;

	// Home-slot reduction: one 4-bit digit of the padded key per cycle
	localparam int DIG_W    = 4;
	localparam int DIGITS   = 8;
	localparam int DIGCNT_W = 3;

	// Request operations
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_REMOVE = 2'd2
	} req_op_t;

	// Reply status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	// One request word as it travels from front end to probe engine
	typedef struct packed {
		req_op_t          op;
		logic [KEY_W-1:0] key;
	} lpht_req_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CALC,
		F_HOLD
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_PROBE
	} back_state_t;

endpackage

`default_nettype wire

// ----- design/linear_probe_hash_table_top.sv -----
// Top level of the linear-probing hash table: front end, queue, probe engine.
// Depends on lpht_pkg, lpht_front, lpht_queue and lpht_back.
//
// A request is taken when start is high and busy low. The front end reduces
// the key to its home slot, one 4-bit digit per cycle, then hands the word to a
// two-entry queue, waiting while the queue is full; the probe engine fetches
// the home slot and then probes one slot per cycle, up to TABLE_SIZE slots,
// since the slot memory has a single read port. The reply is registered and
// appears on done/status/slot for exactly one cycle and cannot be held off.
// Front end and engine overlap, so the front end can take a new request while
// the engine is still probing the last one. After reset the engine clears the
// table, during which busy stays high.
`default_nettype none

module linear_probe_hash_table_top import lpht_pkg::*; #(
	parameter int TABLE_SIZE = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [OP_W-1:0]     req_type,
	input  wire logic [KEY_W-1:0]    key,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [SLOT_W-1:0]        slot
);

	localparam int IDX_W = $clog2(TABLE_SIZE);

	lpht_req_t          push_req, pop_req;
	logic [IDX_W-1:0]   push_home, pop_home;
	logic               push, pop, full, empty, clearing;

	lpht_front #(.TABLE_SIZE(TABLE_SIZE), .IDX_W(IDX_W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.hold_off  (clearing),
		.req_type  (req_type),
		.key       (key),
		.full      (full),
		.busy      (busy),
		.push      (push),
		.push_req  (push_req),
		.push_home (push_home)
	);

	lpht_queue #(.IDX_W(IDX_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_req  (push_req),
		.push_home (push_home),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.pop_req   (pop_req),
		.pop_home  (pop_home)
	);

	lpht_back #(.TABLE_SIZE(TABLE_SIZE), .IDX_W(IDX_W)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop_req  (pop_req),
		.pop_home (pop_home),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.status   (status),
		.slot     (slot)
	);

endmodule

`default_nettype wire

// ----- design/lpht_front.sv -----
// Front end: takes a request word and reduces its key to the home slot.
// Depends on lpht_pkg; feeds lpht_queue.
`default_nettype none

module lpht_front import lpht_pkg::*; #(
	parameter int TABLE_SIZE = 16,
	parameter int IDX_W      = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             hold_off,
	input  wire logic [OP_W-1:0]  req_type,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic             full,
	output logic                  busy,
	output logic                  push,
	output lpht_req_t             push_req,
	output logic [IDX_W-1:0]      push_home
);

	localparam int RW = IDX_W + DIG_W;

	front_state_t             state_q, state_d;
	lpht_req_t                req_q;
	logic [DIGITS*DIG_W-1:0]  sh_q;
	logic [IDX_W-1:0]         rem_q;
	logic [DIGCNT_W-1:0]      dig_q;
	logic [RW-1:0]            rem_ext;
	logic [RW-1:0]            rem_sub;
	logic [RW-1:0]            rem_nxt;
	logic                     accept;

	assign busy      = (state_q != F_IDLE) || hold_off;
	assign accept    = start && !busy;
	assign push      = (state_q == F_HOLD) && !full;
	assign push_req  = req_q;
	assign push_home = rem_q;

	// Fold in the next digit: remainder stays below the table size
	always_comb begin
		rem_ext = {rem_q, sh_q[DIGITS*DIG_W-1 -: DIG_W]};
		rem_sub = '0;
		for (int k = 1; k < (1 << DIG_W); k++) begin
			if (rem_ext >= RW'(k * TABLE_SIZE)) begin
				rem_sub = RW'(k * TABLE_SIZE);
			end
		end
		rem_nxt = rem_ext - rem_sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) state_d = F_CALC;
			end
			F_CALC: begin
				if (dig_q == DIGCNT_W'(DIGITS - 1)) state_d = F_HOLD;
			end
			F_HOLD: begin
				if (!full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Capture the word, then advance one digit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q <= '0;
		end else if (accept) begin
			dig_q <= '0;
		end else if (state_q == F_CALC) begin
			dig_q <= dig_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.op  <= req_op_t'(req_type);
			req_q.key <= key;
			sh_q      <= {1'b0, key};
			rem_q     <= '0;
		end else if (state_q == F_CALC) begin
			sh_q  <= {sh_q[DIGITS*DIG_W-DIG_W-1:0], {DIG_W{1'b0}}};
			rem_q <= rem_nxt[IDX_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- design/lpht_queue.sv -----
// Two-entry queue of classified request words between front end and probe engine.
// Depends on lpht_pkg.
`default_nettype none

module lpht_queue import lpht_pkg::*; #(
	parameter int IDX_W = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lpht_req_t        push_req,
	input  wire logic [IDX_W-1:0] push_home,
	input  wire logic             pop,
	output logic                  full,
	output logic                  empty,
	output lpht_req_t             pop_req,
	output logic [IDX_W-1:0]      pop_home
);

	lpht_req_t          req_q  [2];
	logic [IDX_W-1:0]   home_q [2];
	logic               wp_q, rp_q;
	logic [1:0]         cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_req  = req_q[rp_q];
	assign pop_home = home_q[rp_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Hold the words
	always_ff @(posedge clk) begin
		if (push) begin
			req_q[wp_q]  <= push_req;
			home_q[wp_q] <= push_home;
		end
	end

endmodule

`default_nettype wire

// ----- design/lpht_back.sv -----
// Probe engine: slot memory, clearing pass, linear probe and reply register.
// Depends on lpht_pkg; pops words from lpht_queue.
`default_nettype none

module lpht_back import lpht_pkg::*; #(
	parameter int TABLE_SIZE = 16,
	parameter int IDX_W      = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               empty,
	input  wire lpht_req_t          pop_req,
	input  wire logic [IDX_W-1:0]   pop_home,
	output logic                    pop,
	output logic                    clearing,
	output logic                    done,
	output logic [STATUS_W-1:0]     status,
	output logic [SLOT_W-1:0]       slot
);

	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);

	// Each entry: valid mark over the stored key
	logic [KEY_W:0]      mem [TABLE_SIZE];
	logic [KEY_W:0]      rdata_q;

	back_state_t         state_q, state_d;
	lpht_req_t           cur_q, cur_d;
	logic [IDX_W-1:0]    iss_q, iss_d;
	logic [IDX_W-1:0]    ev_q, ev_d;
	logic [IDX_W-1:0]    cnt_q, cnt_d;
	logic [IDX_W-1:0]    clr_q, clr_d;
	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    wr_addr;
	logic [KEY_W:0]      wr_data;
	logic                wr_en;
	logic                hit;
	logic                res_set;
	status_t             res_status;
	logic                res_ok;
	logic [SLOT_W-1:0]   ev_slot;
	logic                done_q;
	status_t             status_q;
	logic [SLOT_W-1:0]   slot_q;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
		wrap_inc = (p == LAST) ? '0 : p + 1'b1;
	endfunction

	generate
		if (IDX_W >= SLOT_W) begin : g_slot_trunc
			assign ev_slot = ev_q[SLOT_W-1:0];
		end else begin : g_slot_ext
			assign ev_slot = {{(SLOT_W-IDX_W){1'b0}}, ev_q};
		end
	endgenerate

	assign clearing = (state_q == B_CLEAR);
	assign done     = done_q;
	assign status   = status_q;
	assign slot     = slot_q;

	// Slot memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	assign hit = (cur_q.op == OP_INSERT) ? !rdata_q[KEY_W]
	           : (rdata_q[KEY_W] && (rdata_q[KEY_W-1:0] == cur_q.key));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			done_q  <= res_set;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		iss_q <= iss_d;
		ev_q  <= ev_d;
		cnt_q <= cnt_d;
		if (res_set) begin
			status_q <= res_status;
			slot_q   <= res_ok ? ev_slot : '0;
		end
	end

	// Sequence the clearing pass and the probe of one word
	always_comb begin
		state_d    = state_q;
		cur_d      = cur_q;
		iss_d      = iss_q;
		ev_d       = ev_q;
		cnt_d      = cnt_q;
		clr_d      = clr_q;
		rd_addr    = iss_q;
		wr_en      = 1'b0;
		wr_addr    = ev_q;
		wr_data    = {1'b0, cur_q.key};
		pop        = 1'b0;
		res_set    = 1'b0;
		res_status = ST_MISS;
		res_ok     = 1'b0;
		unique case (state_q)
			B_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				clr_d   = wrap_inc(clr_q);
				if (clr_q == LAST) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					unique case (pop_req.op) inside
						OP_INSERT, OP_SEARCH, OP_REMOVE: begin
							cur_d   = pop_req;
							ev_d    = pop_home;
							rd_addr = pop_home;
							iss_d   = wrap_inc(pop_home);
							cnt_d   = '0;
							state_d = B_PROBE;
						end
						default: begin
							// unused operation: reply not found at once
							res_set = 1'b1;
						end
					endcase
				end
			end
			B_PROBE: begin
				if (hit) begin
					wr_en      = (cur_q.op != OP_SEARCH);
					wr_data    = {(cur_q.op == OP_INSERT), cur_q.key};
					res_set    = 1'b1;
					res_status = ST_OK;
					res_ok     = 1'b1;
					state_d    = B_IDLE;
				end else if (cnt_q == LAST) begin
					res_set    = 1'b1;
					res_status = (cur_q.op == OP_INSERT) ? ST_FULL : ST_MISS;
					state_d    = B_IDLE;
				end else begin
					ev_d  = iss_q;
					iss_d = wrap_inc(iss_q);
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ----- design/lpht_checker.sv -----
// Port-level checks for the hash table top level, attached by bind.
// Depends on lpht_pkg and linear_probe_hash_table_top.
`default_nettype none

module lpht_checker import lpht_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                done,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [SLOT_W-1:0]   slot
);

	// Reply carries a defined status
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_FULL || status == ST_MISS))
		else $error("reply status code undefined");

	// Failed replies report slot zero
	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (slot == '0))
		else $error("failed reply with nonzero slot");

	// An accepted word occupies the front end
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after accepting a word");

	// Clearing pass blocks requests straight after reset
	a_busy_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> busy)
		else $error("request port open before table clear");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (.*);

`default_nettype wire

// ----- verif/tb_linear_probe_hash_table_top.sv -----
// Self-checking testbench for linear_probe_hash_table_top: directed and random
// insert, search, remove and unused-code words, checked against an in-bench table model.
// Depends on lpht_pkg and the design under verif's parent design folder.
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_top;
	import lpht_pkg::*;

	localparam int TABLE_SIZE    = 16;
	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 7;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES        = 9;
	localparam int PHASE_WORDS   = 200;
	localparam int POOL_SIZE     = 32;

	// request code the block must treat as a miss with no side effect
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [KEY_W-1:0] KEY_MAX  = {KEY_W{1'b1}};

	typedef struct packed {
		logic [STATUS_W-1:0] code;
		logic [SLOT_W-1:0]   index;
	} reply_t;

	// Table model plus the queue of replies still owed by the block
	class hash_table_scoreboard;
		localparam int SLOTS = TABLE_SIZE;

		logic [KEY_W-1:0] stored_key [SLOTS];
		bit               occupied   [SLOTS];
		reply_t           replies_due[$];
		int unsigned      mismatches;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				occupied[i]   = 1'b0;
				stored_key[i] = '0;
			end
			mismatches = 0;
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		// Apply one accepted request word and queue the reply it owes
		function void note_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
			int     home;
			int     pos;
			int     hit;
			reply_t due;
			home = int'(k % SLOTS);
			hit  = -1;
			due.code  = ST_MISS;
			due.index = '0;
			case (op)
				OP_INSERT: begin
					// first free slot, probing forward with wrap-around
					for (int n = 0; n < SLOTS; n++) begin
						pos = (home + n) % SLOTS;
						if (hit < 0 && !occupied[pos])
							hit = pos;
					end
					if (hit < 0) begin
						due.code = ST_FULL;
					end else begin
						stored_key[hit] = k;
						occupied[hit]   = 1'b1;
						due.code        = ST_OK;
						due.index       = SLOT_W'(hit);
					end
				end
				OP_SEARCH, OP_REMOVE: begin
					// first valid slot holding the key
					for (int n = 0; n < SLOTS; n++) begin
						pos = (home + n) % SLOTS;
						if (hit < 0 && occupied[pos] && stored_key[pos] == k)
							hit = pos;
					end
					if (hit >= 0) begin
						if (op == OP_REMOVE)
							occupied[hit] = 1'b0;
						due.code  = ST_OK;
						due.index = SLOT_W'(hit);
					end
				end
				default: begin
					due.code = ST_MISS;
				end
			endcase
			replies_due.push_back(due);
		endfunction

		task report(input string what);
			mismatches++;
			$display("%0t mismatch: %s", $time, what);
		endtask

		// Compare one reply word with the oldest one owed
		task check_reply(input logic [STATUS_W-1:0] code, input logic [SLOT_W-1:0] index);
			reply_t want;
			if (replies_due.size() == 0) begin
				report($sformatf("reply status %0d slot %0d with none owed", code, index));
				return;
			end
			want = replies_due.pop_front();
			if (code !== want.code)
				report($sformatf("status %0d, wanted %0d", code, want.code));
			if (index !== want.index)
				report($sformatf("slot %0d, wanted %0d", index, want.index));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [OP_W-1:0]     req_type;
	logic [KEY_W-1:0]    key;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;

	hash_table_scoreboard sb;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int unsigned      quiet_cycles;

	linear_probe_hash_table_top #(
		.TABLE_SIZE(TABLE_SIZE)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req_type(req_type),
		.key     (key),
		.done    (done),
		.status  (status),
		.slot    (slot)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Note accepted request words and check reply words at the edge that takes them
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(req_type, key);
			if (done)
				sb.check_reply(status, slot);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Idle for gap cycles, then present one word and hold it until taken
	task automatic issue(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			start    <= 1'b0;
			req_type <= OP_W'($urandom);
			key      <= KEY_W'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start    <= 1'b1;
		req_type <= op;
		key      <= k;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
	endtask

	// Mostly short gaps, some medium, a few long; none in a steady phase
	function automatic int gap_len(input bit steady);
		int r;
		r = $urandom_range(99);
		if (steady || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(4, 1);
		if (r < 97)
			return $urandom_range(30, 5);
		return $urandom_range(60, 31);
	endfunction

	// Favour keys held in the table for lookups, pool keys for duplicates
	function automatic logic [KEY_W-1:0] choose_key(input logic [OP_W-1:0] op);
		int idx;
		idx = $urandom_range(TABLE_SIZE - 1);
		if (op != OP_INSERT && $urandom_range(99) < 60 && sb.occupied[idx])
			return sb.stored_key[idx];
		if ($urandom_range(99) < 75)
			return key_pool[$urandom_range(POOL_SIZE - 1)];
		return KEY_W'($urandom);
	endfunction

	initial begin
		int               ins_pct;
		int               roll;
		bit               steady;
		logic [OP_W-1:0]  op;

		sb       = new();
		arst_n   = 1'b0;
		start    = 1'b0;
		req_type = '0;
		key      = '0;
		quiet_cycles = 0;

		// half the pool holds keys below 64, so keys repeat and home slots collide
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = (i < POOL_SIZE / 2) ? KEY_W'($urandom_range(63)) : KEY_W'($urandom);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, unused code, collisions, duplicates, wrap, full table
		issue(OP_SEARCH, 31'h2AAAAAAA, 0);
		issue(OP_UNUSED, 31'h55555555, 0);
		issue(OP_INSERT, '0, 0);
		issue(OP_INSERT, KEY_MAX, 0);
		issue(OP_INSERT, 31'd16, 2);
		issue(OP_INSERT, '0, 0);
		issue(OP_SEARCH, '0, 0);
		issue(OP_REMOVE, '0, 5);
		issue(OP_SEARCH, '0, 0);
		issue(OP_REMOVE, 31'd5, 0);
		for (int i = 0; i < 13; i++)
			issue(OP_INSERT, KEY_W'(31 + 16 * i), i % 3);
		issue(OP_INSERT, 31'd7, 0);
		issue(OP_SEARCH, 31'd3, 0);

		// Random phases with varying insert pressure and idling
		for (int ph = 0; ph < PHASES; ph++) begin
			ins_pct = $urandom_range(70, 15);
			steady  = ($urandom_range(2) == 0);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				roll = $urandom_range(99);
				if (roll < ins_pct)
					op = OP_INSERT;
				else if (roll < ins_pct + 5)
					op = OP_UNUSED;
				else if (roll % 2 == 0)
					op = OP_SEARCH;
				else
					op = OP_REMOVE;
				if ($urandom_range(49) == 0)
					key_pool[$urandom_range(POOL_SIZE - 1)] = KEY_W'($urandom);
				issue(op, choose_key(op), gap_len(steady));
			end
		end

		@(negedge clk);
		start <= 1'b0;

		// drain owed replies, then watch for strays
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
